// ----- rtl/core/bmhq_pkg.sv -----
// Shared types and codes for the binary min-heap queue.
package bmhq_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 7;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_LAST,
    S_POP_LD,
    S_POP_RD,
    S_POP_CMP,
    S_DONE
  } bmhq_state_e;

  typedef enum logic [1:0] {
    RD_PARENT,
    RD_LAST,
    RD_CHILD
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_MOV,
    WR_PARENT,
    WR_CHILD
  } wr_sel_e;

  typedef struct packed {
    logic    accept;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    ld_mov;
    logic    load_out;
  } bmhq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic one;
    logic hole_zero;
    logic no_child;
    logic up_swap;
    logic down_swap;
    logic out_free;
  } bmhq_sts_t;

endpackage

// ----- rtl/core/bmhq_ram.sv -----
// Generic simple RAM: one write port, two read ports with registered read data.
module bmhq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- rtl/core/bmhq_ctrl.sv -----
// Sequencer for push sift-up and pop sift-down over the heap datapath.
module bmhq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                func_i,
  output logic                in_ready_o,
  input  bmhq_pkg::bmhq_sts_t sts_i,
  output bmhq_pkg::bmhq_cmd_t cmd_o
);
  import bmhq_pkg::*;

  bmhq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_PUSH) begin
            state_d = sts_i.full ? S_DONE : S_PUSH_RD;
          end else begin
            state_d = (sts_i.empty || sts_i.one) ? S_DONE : S_POP_LAST;
          end
        end
      end
      S_PUSH_RD:  state_d = sts_i.hole_zero ? S_DONE : S_PUSH_CMP;
      S_PUSH_CMP: state_d = sts_i.up_swap ? S_PUSH_RD : S_DONE;
      S_POP_LAST: state_d = S_POP_LD;
      S_POP_LD:   state_d = S_POP_RD;
      S_POP_RD:   state_d = sts_i.no_child ? S_DONE : S_POP_CMP;
      S_POP_CMP:  state_d = sts_i.down_swap ? S_POP_RD : S_DONE;
      S_DONE:     state_d = sts_i.out_free ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_sel = RD_PARENT;
    cmd_o.wr_sel = WR_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_PUSH_RD: begin
        cmd_o.rd_sel = RD_PARENT;
        if (sts_i.hole_zero) begin
          cmd_o.wr_sel = WR_MOV;
        end
      end
      S_PUSH_CMP: begin
        cmd_o.wr_sel = sts_i.up_swap ? WR_PARENT : WR_MOV;
      end
      S_POP_LAST: begin
        cmd_o.rd_sel = RD_LAST;
      end
      S_POP_LD: begin
        cmd_o.ld_mov = 1'b1;
      end
      S_POP_RD: begin
        cmd_o.rd_sel = RD_CHILD;
        if (sts_i.no_child) begin
          cmd_o.wr_sel = WR_MOV;
        end
      end
      S_POP_CMP: begin
        cmd_o.wr_sel = sts_i.down_swap ? WR_CHILD : WR_MOV;
      end
      S_DONE: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A sift only starts from an accepted request, and each state issues one write at most.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && !in_valid_i |=> (state_q == S_IDLE))
    else $error("sequencer left idle without a request");

endmodule

// ----- rtl/core/bmhq_dp.sv -----
// Heap datapath: entry store, hole pointer, moving entry, root copy and result register.
module bmhq_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                func_i,
  input  logic [bmhq_pkg::KeyW-1:0]           key_i,
  input  logic [bmhq_pkg::PayloadW-1:0]       payload_i,
  input  bmhq_pkg::bmhq_cmd_t                 cmd_i,
  output bmhq_pkg::bmhq_sts_t                 sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bmhq_pkg::StatusW-1:0]        status_o,
  output logic [bmhq_pkg::KeyW-1:0]           popped_key_o,
  output logic [bmhq_pkg::PayloadW-1:0]       popped_payload_o,
  output logic                                top_valid_o,
  output logic [bmhq_pkg::KeyW-1:0]           top_key_o,
  output logic [bmhq_pkg::PayloadW-1:0]       top_payload_o,
  output logic [bmhq_pkg::CountW-1:0]         entry_count_o
);
  import bmhq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;
  localparam int unsigned EW = $bits(entry_t);

  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] hole_q, hole_d;
  entry_t        mov_q, mov_d;
  entry_t        top_q;
  entry_t        popped_q, popped_d;
  status_e       st_q, st_d;

  logic          out_valid_q;
  status_e       out_status_q;
  entry_t        out_popped_q;
  logic          out_top_valid_q;
  entry_t        out_top_q;
  logic [CountW-1:0] out_count_q;

  logic [EW-1:0] rdata_a, rdata_b;
  entry_t        rd_a, rd_b;
  logic [AW-1:0] raddr_a, raddr_b;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  logic [AW-1:0] parent;
  logic [XW-1:0] left_x, right_x, count_x;
  logic          left_ok, right_ok;
  logic          best_l, best_r;
  logic [KeyW-1:0] cand_key;
  logic [CW+CountW-1:0] count_wide;

  assign rd_a = entry_t'(rdata_a);
  assign rd_b = entry_t'(rdata_b);

  assign parent  = (hole_q - AW'(1)) >> 1;
  assign left_x  = {1'b0, hole_q, 1'b1};
  assign right_x = left_x + XW'(1);
  assign count_x = XW'(count_q);
  assign left_ok  = left_x < count_x;
  assign right_ok = right_x < count_x;

  // Smaller child wins, left on equal keys; swap only when strictly smaller than the mover.
  assign best_l   = left_ok && (rd_a.key < mov_q.key);
  assign cand_key = best_l ? rd_a.key : mov_q.key;
  assign best_r   = right_ok && (rd_b.key < cand_key);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_LAST:  raddr_a = count_q[AW-1:0];
      RD_CHILD: raddr_a = left_x[AW-1:0];
      default:  raddr_a = parent;
    endcase
    raddr_b = right_x[AW-1:0];
  end

  always_comb begin
    we    = cmd_i.wr_sel != WR_NONE;
    waddr = hole_q;
    case (cmd_i.wr_sel)
      WR_PARENT: wdata = rd_a;
      WR_CHILD:  wdata = best_r ? rd_b : rd_a;
      default:   wdata = mov_q;
    endcase
  end

  bmhq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  always_comb begin
    count_d  = count_q;
    hole_d   = hole_q;
    mov_d    = mov_q;
    popped_d = popped_q;
    st_d     = st_q;
    if (cmd_i.accept) begin
      popped_d = '0;
      st_d     = STATUS_DONE;
      if (func_i == FUNC_PUSH) begin
        if (sts_o.full) begin
          st_d = STATUS_PUSH_FULL;
        end else begin
          hole_d  = count_q[AW-1:0];
          mov_d   = '{key: key_i, payload: payload_i};
          count_d = count_q + CW'(1);
        end
      end else begin
        if (sts_o.empty) begin
          st_d = STATUS_POP_EMPTY;
        end else begin
          popped_d = top_q;
          hole_d   = '0;
          count_d  = count_q - CW'(1);
        end
      end
    end
    if (cmd_i.ld_mov) begin
      mov_d = rd_a;
    end
    case (cmd_i.wr_sel)
      WR_PARENT: hole_d = parent;
      WR_CHILD:  hole_d = best_r ? right_x[AW-1:0] : left_x[AW-1:0];
      default:   hole_d = hole_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q   <= hole_d;
    mov_q    <= mov_d;
    popped_q <= popped_d;
    st_q     <= st_d;
    // Keep a copy of the root so results never need a store read.
    if (we && (waddr == '0)) begin
      top_q <= wdata;
    end
    if (cmd_i.load_out) begin
      out_status_q    <= st_q;
      out_popped_q    <= popped_q;
      out_top_valid_q <= !sts_o.empty;
      out_top_q       <= sts_o.empty ? '0 : top_q;
      out_count_q     <= count_wide[CountW-1:0];
    end
  end

  assign count_wide = {{CountW{1'b0}}, count_q};

  assign sts_o.full      = count_q == CW'(CAPACITY);
  assign sts_o.empty     = count_q == '0;
  assign sts_o.one       = count_q == CW'(1);
  assign sts_o.hole_zero = hole_q == '0;
  assign sts_o.no_child  = !left_ok;
  assign sts_o.up_swap   = mov_q.key < rd_a.key;
  assign sts_o.down_swap = best_l || best_r;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign popped_key_o     = out_popped_q.key;
  assign popped_payload_o = out_popped_q.payload;
  assign top_valid_o      = out_top_valid_q;
  assign top_key_o        = out_top_q.key;
  assign top_payload_o    = out_top_q.payload;
  assign entry_count_o    = out_count_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(hole_q) < count_q))
    else $error("store write outside the occupied range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_sel == WR_CHILD) |-> (wdata.key < mov_q.key))
    else $error("sift-down moved a child that is not smaller");

endmodule

// ----- rtl/core/binary_min_heap_queue.sv -----
// Binary min-heap priority queue: push key/payload entries, pop the smallest key.
// A request is taken only while no sift is running; its result lands in an output
// register, so the next request can enter while that result waits. The next request
// can be accepted in the cycle after the one that loads the previous result. For each
// tree level a push climbs, it does one store read, then one compare and write. A pop
// first reads the last entry and loads it as the moving entry, then for each level it
// sinks does one read of both children, then one compare and write. Error requests
// (push when full, pop when empty) and pops that empty the heap go straight to loading
// their result, with no sift. A result that waits at the output stalls the next one
// from loading. The store has one write port and two read ports, so a sift-down step
// reads both children together.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [bmhq_pkg::KeyW-1:0]     key_i,
  input  logic [bmhq_pkg::PayloadW-1:0] payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bmhq_pkg::StatusW-1:0]  status_o,
  output logic [bmhq_pkg::KeyW-1:0]     popped_key_o,
  output logic [bmhq_pkg::PayloadW-1:0] popped_payload_o,
  output logic                          top_valid_o,
  output logic [bmhq_pkg::KeyW-1:0]     top_key_o,
  output logic [bmhq_pkg::PayloadW-1:0] top_payload_o,
  output logic [bmhq_pkg::CountW-1:0]   entry_count_o
);
  import bmhq_pkg::*;

  bmhq_cmd_t cmd;
  bmhq_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .func_i    (func_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bmhq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (func_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .popped_key_o    (popped_key_o),
    .popped_payload_o(popped_payload_o),
    .top_valid_o     (top_valid_o),
    .top_key_o       (top_key_o),
    .top_payload_o   (top_payload_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the binary min-heap queue: directed table, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned RAND_ITEMS  = 1950;
  localparam int unsigned PHASE_LEN   = 150;
  localparam int unsigned IDLE_PCT    = 31;
  localparam int unsigned HOLD_AFTER  = 500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct packed {
    status_e             status;
    logic [KeyW-1:0]     popped_key;
    logic [PayloadW-1:0] popped_payload;
    logic                top_valid;
    logic [KeyW-1:0]     top_key;
    logic [PayloadW-1:0] top_payload;
    logic [CountW-1:0]   count;
  } heap_result_t;

  typedef struct packed {
    func_e               func;
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
    logic                typed;
    heap_result_t        want;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 20;

  // Rows marked typed carry their result by hand; the rest take their result from the predictor.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{FUNC_POP,  32'h0, 32'h0, 1'b1,
      '{STATUS_POP_EMPTY, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 7'd0}},
    '{FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{STATUS_DONE, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1}},
    '{FUNC_PUSH, 32'h0, 32'h0, 1'b1,
      '{STATUS_DONE, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0, 7'd2}},
    '{FUNC_PUSH, 32'h0, 32'hA5A5_A5A5, 1'b1,
      '{STATUS_DONE, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0, 7'd3}},
    '{FUNC_PUSH, 32'h1, 32'h5A5A_5A5A, 1'b0, '0},
    '{FUNC_POP,  32'h0, 32'h0, 1'b0, '0},
    '{FUNC_POP,  32'h0, 32'h0, 1'b0, '0},
    '{FUNC_POP,  32'h0, 32'h0, 1'b0, '0},
    '{FUNC_POP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{STATUS_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 7'd0}},
    '{FUNC_POP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{STATUS_POP_EMPTY, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0, 7'd0}},
    '{FUNC_PUSH, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{FUNC_PUSH, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{FUNC_PUSH, 32'h3, 32'h1, 1'b0, '0},
    '{FUNC_PUSH, 32'h3, 32'h2, 1'b0, '0},
    '{FUNC_PUSH, 32'h3, 32'h3, 1'b0, '0},
    '{FUNC_POP,  32'h0, 32'h0, 1'b0, '0},
    '{FUNC_POP,  32'h0, 32'h0, 1'b0, '0},
    '{FUNC_POP,  32'h0, 32'h0, 1'b0, '0},
    '{FUNC_POP,  32'h0, 32'h0, 1'b0, '0},
    '{FUNC_POP,  32'h0, 32'h0, 1'b1,
      '{STATUS_DONE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 7'd0}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                func_i;
  logic [KeyW-1:0]     key_i;
  logic [PayloadW-1:0] payload_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [StatusW-1:0]  status_o;
  logic [KeyW-1:0]     popped_key_o;
  logic [PayloadW-1:0] popped_payload_o;
  logic                top_valid_o;
  logic [KeyW-1:0]     top_key_o;
  logic [PayloadW-1:0] top_payload_o;
  logic [CountW-1:0]   entry_count_o;

  logic [KeyW-1:0]     heap_key [CAPACITY];
  logic [PayloadW-1:0] heap_payload [CAPACITY];
  int unsigned         heap_fill;

  heap_result_t        pending_results [$];
  int unsigned         mismatch_count;
  int unsigned         results_checked;
  logic                no_gaps;

  binary_min_heap_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .popped_key_o    (popped_key_o),
    .popped_payload_o(popped_payload_o),
    .top_valid_o     (top_valid_o),
    .top_key_o       (top_key_o),
    .top_payload_o   (top_payload_o),
    .entry_count_o   (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KeyW-1:0]     k;
    logic [PayloadW-1:0] p;
    k = heap_key[a];
    p = heap_payload[a];
    heap_key[a] = heap_key[b];
    heap_payload[a] = heap_payload[b];
    heap_key[b] = k;
    heap_payload[b] = p;
  endfunction

  // Apply one request to the shadow heap and return the result it must produce.
  function automatic heap_result_t predict_heap_step(func_e f, logic [KeyW-1:0] k,
                                                     logic [PayloadW-1:0] p);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  up;
    int unsigned  lc;
    int unsigned  rc;
    int unsigned  best;
    logic         moving;
    r = '0;
    r.status = STATUS_DONE;
    if (f == FUNC_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        r.status = STATUS_PUSH_FULL;
      end else begin
        heap_key[heap_fill] = k;
        heap_payload[heap_fill] = p;
        pos = heap_fill;
        moving = 1'b1;
        while (moving && pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_key[pos] < heap_key[up]) begin
            swap_slots(pos, up);
            pos = up;
          end else begin
            moving = 1'b0;
          end
        end
        heap_fill++;
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = STATUS_POP_EMPTY;
      end else begin
        r.popped_key = heap_key[0];
        r.popped_payload = heap_payload[0];
        heap_fill--;
        heap_key[0] = heap_key[heap_fill];
        heap_payload[0] = heap_payload[heap_fill];
        pos = 0;
        moving = 1'b1;
        // Sink toward the smaller child; the left one wins a tie.
        while (moving) begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          best = pos;
          if (lc < heap_fill && heap_key[lc] < heap_key[best]) best = lc;
          if (rc < heap_fill && heap_key[rc] < heap_key[best]) best = rc;
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    if (heap_fill > 0) begin
      r.top_valid = 1'b1;
      r.top_key = heap_key[0];
      r.top_payload = heap_payload[0];
    end
    r.count = CountW'(heap_fill);
    return r;
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(3))
      0: return KeyW'($urandom_range(15));
      1: begin
        case ($urandom_range(3))
          0: return 32'h0;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Offer one request, hold it until taken, then record what it must produce.
  task automatic send_request(func_e f, logic [KeyW-1:0] k, logic [PayloadW-1:0] p,
                              logic typed, heap_result_t want);
    heap_result_t predicted;
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = f;
    key_i = k;
    payload_i = p;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_heap_step(f, k, p);
    if (typed) pending_results.push_back(want);
    else pending_results.push_back(predicted);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    heap_result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        exp = pending_results.pop_front();
        check_field("status", 32'(exp.status), 32'(status_o));
        check_field("popped_key", exp.popped_key, popped_key_o);
        check_field("popped_payload", exp.popped_payload, popped_payload_o);
        check_field("top_valid", 32'(exp.top_valid), 32'(top_valid_o));
        check_field("top_key", exp.top_key, top_key_o);
        check_field("top_payload", exp.top_payload, top_payload_o);
        check_field("entry_count", 32'(exp.count), 32'(entry_count_o));
      end
      results_checked++;
    end
  end

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else if (no_gaps) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int unsigned push_pct;
    func_e       f;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FUNC_PUSH;
    key_i = '0;
    payload_i = '0;
    no_gaps = 1'b0;
    mismatch_count = 0;
    results_checked = 0;
    heap_fill = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(DIRECTED[i].func, DIRECTED[i].key, DIRECTED[i].payload,
                   DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Alternate fill, drain and mixed phases so the heap hits both full and empty.
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      case ((i / PHASE_LEN) % 3)
        0: push_pct = 90;
        1: push_pct = 10;
        default: push_pct = 55;
      endcase
      no_gaps = (i >= 900 && i < 1200);
      f = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
      send_request(f, pick_key(), $urandom(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
